// ===== hdl/incremental_pi_valve_positioner_assert.svh =====
// assertion macros for the valve positioner checker
// no dependencies; included by the checker file only
`ifndef INCREMENTAL_PI_VALVE_POSITIONER_ASSERT_SVH
`define INCREMENTAL_PI_VALVE_POSITIONER_ASSERT_SVH

// same-cycle implication, always active
`define IPVP_ASSERT_NOW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("ipvp check failed");

// next-cycle implication, off during reset
`define IPVP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipvp check failed");

`endif

// ===== hdl/ipvp_pkg.sv =====
// shared types, constants and microcode rom of the valve positioner
// used by ipvp_seq, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none
package ipvp_pkg;

   localparam int unsigned StepW    = 3;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 24;
   localparam int unsigned MulAW    = 25;
   localparam int unsigned MulBW    = 18;
   localparam int unsigned MulPW    = MulAW + MulBW;
   localparam int unsigned AccW     = 58;

   localparam logic [15:0] PosFull = 16'd51200;

   localparam logic [CsrIdxW-1:0] RegSetpoint = 3'd0;
   localparam logic [CsrIdxW-1:0] RegPropGain = 3'd1;
   localparam logic [CsrIdxW-1:0] RegInvItime = 3'd2;
   localparam logic [CsrIdxW-1:0] RegInvAct   = 3'd3;

   typedef struct packed {
      logic signed [15:0] measured_temp;
      logic [15:0]        step_seconds;
   } req_type;

   typedef struct packed {
      logic [15:0] valve_position;
      logic        clamped;
   } rsp_type;

   typedef enum logic [2:0] {
      A_IIT,
      A_RATE_LO,
      A_RATE_HI,
      A_COARSE_LO,
      A_COARSE_HI
   } a_sel_type;

   typedef enum logic [1:0] {
      B_STEP,
      B_ERR,
      B_GAIN
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_CHG,
      ACC_LOAD_PROD,
      ACC_ADD_PROD,
      ACC_ADD_PROD_HI
   } acc_op_type;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_RSP
   } wait_type;

   typedef struct packed {
      wait_type   wait_on;
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      logic       mul_en;
      acc_op_type acc_op;
      logic       take_req;
      logic       save_rate;
      logic       finish;
   } ucode_type;

   function automatic ucode_type ucode(input logic [StepW-1:0] step);
      ucode_type w;
      w = '{WAIT_NONE, A_IIT, B_STEP, 1'b0, ACC_HOLD, 1'b0, 1'b0, 1'b0};
      case (step)
         3'd0: begin  // error, change, rate = step * 1/I
            w.wait_on  = WAIT_REQ;
            w.a_sel    = A_IIT;
            w.b_sel    = B_STEP;
            w.mul_en   = 1'b1;
            w.take_req = 1'b1;
         end
         3'd1: begin  // low rate part * error, change into acc
            w.a_sel     = A_RATE_LO;
            w.b_sel     = B_ERR;
            w.mul_en    = 1'b1;
            w.save_rate = 1'b1;
            w.acc_op    = ACC_LOAD_CHG;
         end
         3'd2: begin  // high rate part * error
            w.a_sel  = A_RATE_HI;
            w.b_sel  = B_ERR;
            w.mul_en = 1'b1;
            w.acc_op = ACC_ADD_PROD;
         end
         3'd3: begin
            w.acc_op = ACC_ADD_PROD_HI;
         end
         3'd4: begin  // low coarse part * gain
            w.a_sel  = A_COARSE_LO;
            w.b_sel  = B_GAIN;
            w.mul_en = 1'b1;
         end
         3'd5: begin  // high coarse part * gain
            w.a_sel  = A_COARSE_HI;
            w.b_sel  = B_GAIN;
            w.mul_en = 1'b1;
            w.acc_op = ACC_LOAD_PROD;
         end
         3'd6: begin
            w.acc_op = ACC_ADD_PROD_HI;
         end
         3'd7: begin  // position update, clamp, response
            w.wait_on = WAIT_RSP;
            w.finish  = 1'b1;
         end
         default: begin
            w.wait_on = WAIT_NONE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ipvp_seq.sv =====
// microcode sequencer: step counter, rom lookup and wait-on-condition jumps
// depends on ipvp_pkg
`timescale 1ns / 1ps
`default_nettype none
module ipvp_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_ready,
   input  wire logic               rsp_free,
   output ipvp_pkg::ucode_type     ctl
);

   logic [ipvp_pkg::StepW-1:0] step_ff;
   logic [ipvp_pkg::StepW-1:0] step_in;
   ipvp_pkg::ucode_type        word;
   logic                       go;

   assign word = ipvp_pkg::ucode(step_ff);

   always_comb begin
      case (word.wait_on)
         ipvp_pkg::WAIT_REQ: go = req_ready;
         ipvp_pkg::WAIT_RSP: go = rsp_free;
         default:            go = 1'b1;
      endcase
   end

   // unmet condition jumps back to the same step
   assign step_in = go ? step_ff + 1'b1 : step_ff;

   always_comb begin
      ctl = word;
      if (!go) begin
         ctl.mul_en    = 1'b0;
         ctl.acc_op    = ipvp_pkg::ACC_HOLD;
         ctl.take_req  = 1'b0;
         ctl.save_rate = 1'b0;
         ctl.finish    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/incremental_pi_valve_positioner.sv =====
// velocity-form pi valve positioner: config registers, shared multiplier datapath
// depends on ipvp_pkg and ipvp_seq
//
//   channel  ports                       payload
//   request  req_valid / req_stall       req_data  (ipvp_pkg::req_type)
//   response rsp_valid / rsp_stall       rsp_data  (ipvp_pkg::rsp_type)
//   csr      csr_we, csr_index           csr_wdata (24 bit, write only)
//
// each request runs an 8-step microcode program around one shared
// 25x18 multiplier and a 58-bit accumulator
// a request is buffered while the previous one still computes
// the response register holds a finished result under rsp_stall; the last step
// waits on it only when the next result is ready first
// synchronous reset clears position, previous error and config to defaults
`timescale 1ns / 1ps
`default_nettype none
module incremental_pi_valve_positioner (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ipvp_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ipvp_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [ipvp_pkg::CsrIdxW-1:0]        csr_index,
   input  wire logic [ipvp_pkg::CsrDataW-1:0]       csr_wdata
);

   localparam int unsigned AccW = ipvp_pkg::AccW;
   localparam int unsigned PW   = ipvp_pkg::MulPW;

   // config
   logic signed [15:0] setpoint_ff;
   logic [15:0]        gain_ff;
   logic [23:0]        iit_ff;
   logic               inv_ff;

   // request buffer
   ipvp_pkg::req_type in_ff;
   logic              in_full_ff;
   logic              in_full_in;

   // datapath
   logic signed [16:0]      err_ff;
   logic signed [16:0]      err_in;
   logic signed [17:0]      chg_ff;
   logic signed [17:0]      chg_in;
   logic signed [16:0]      prev_err_ff;
   logic [15:0]             pos_ff;
   logic [15:0]             rate_hi_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [AccW-1:0]  acc_ff;
   logic signed [AccW-1:0]  acc_in;
   logic signed [AccW-1:0]  prod_ext;
   logic signed [ipvp_pkg::MulAW-1:0] mul_a;
   logic signed [ipvp_pkg::MulBW-1:0] mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [42:0]      sdelta;
   logic signed [43:0]      pos_sum;
   logic [15:0]             pos_new;
   logic                    clamp_new;

   // response register
   ipvp_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_free;

   ipvp_pkg::ucode_type ctl;

   ipvp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ready (in_full_ff),
      .rsp_free  (rsp_free),
      .ctl       (ctl)
   );

   assign req_stall = in_full_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      in_full_in = in_full_ff;
      if (ctl.take_req) begin
         in_full_in = 1'b0;
      end else if (req_valid && !in_full_ff) begin
         in_full_in = 1'b1;
      end
   end

   assign err_in = {in_ff.measured_temp[15], in_ff.measured_temp}
                 - {setpoint_ff[15], setpoint_ff};
   assign chg_in = {err_in[16], err_in} - {prev_err_ff[16], prev_err_ff};

   // shared multiplier operands
   always_comb begin
      case (ctl.a_sel)
         ipvp_pkg::A_IIT:       mul_a = {1'b0, iit_ff};
         ipvp_pkg::A_RATE_LO:   mul_a = {1'b0, prod_ff[23:0]};
         ipvp_pkg::A_RATE_HI:   mul_a = {9'b0, rate_hi_ff};
         ipvp_pkg::A_COARSE_LO: mul_a = {1'b0, acc_ff[42:19]};
         ipvp_pkg::A_COARSE_HI: mul_a = {{10{acc_ff[AccW-1]}}, acc_ff[AccW-1:43]};
         default:               mul_a = '0;
      endcase
   end

   always_comb begin
      case (ctl.b_sel)
         ipvp_pkg::B_STEP: mul_b = {2'b0, in_ff.step_seconds};
         ipvp_pkg::B_ERR:  mul_b = {err_ff[16], err_ff};
         ipvp_pkg::B_GAIN: mul_b = {2'b0, gain_ff};
         default:          mul_b = '0;
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = {{(AccW-PW){prod_ff[PW-1]}}, prod_ff};

   always_comb begin
      case (ctl.acc_op)
         ipvp_pkg::ACC_LOAD_CHG:    acc_in = {{8{chg_ff[17]}}, chg_ff, 32'b0};
         ipvp_pkg::ACC_LOAD_PROD:   acc_in = prod_ext;
         ipvp_pkg::ACC_ADD_PROD:    acc_in = acc_ff + prod_ext;
         ipvp_pkg::ACC_ADD_PROD_HI: acc_in = acc_ff + {prod_ext[AccW-25:0], 24'b0};
         default:                   acc_in = acc_ff;
      endcase
   end

   // acc holds gain * coarse; drop 16 fraction bits by floor
   assign sdelta  = inv_ff ? -{acc_ff[AccW-1], acc_ff[AccW-1:16]}
                           :  {acc_ff[AccW-1], acc_ff[AccW-1:16]};
   assign pos_sum = {28'b0, pos_ff} + {sdelta[42], sdelta};

   always_comb begin
      if (pos_sum[43]) begin
         pos_new   = '0;
         clamp_new = 1'b1;
      end else if (pos_sum > $signed({28'b0, ipvp_pkg::PosFull})) begin
         pos_new   = ipvp_pkg::PosFull;
         clamp_new = 1'b1;
      end else begin
         pos_new   = pos_sum[15:0];
         clamp_new = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= '0;
         gain_ff      <= 16'd256;
         iit_ff       <= '0;
         inv_ff       <= 1'b0;
         in_full_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
         pos_ff       <= '0;
      end else begin
         in_full_ff   <= in_full_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               ipvp_pkg::RegSetpoint: setpoint_ff <= csr_wdata[15:0];
               ipvp_pkg::RegPropGain: gain_ff     <= csr_wdata[15:0];
               ipvp_pkg::RegInvItime: iit_ff      <= csr_wdata;
               ipvp_pkg::RegInvAct:   inv_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (ctl.finish) begin
            prev_err_ff <= err_ff;
            pos_ff      <= pos_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !in_full_ff) begin
         in_ff <= req_data;
      end
      if (ctl.take_req) begin
         err_ff <= err_in;
         chg_ff <= chg_in;
      end
      if (ctl.mul_en) begin
         prod_ff <= mul_p;
      end
      if (ctl.save_rate) begin
         rate_hi_ff <= prod_ff[39:24];
      end
      acc_ff <= acc_in;
      if (ctl.finish) begin
         rsp_ff.valve_position <= pos_new;
         rsp_ff.clamped        <= clamp_new;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ipvp_checker.sv =====
// port-level checks of the valve positioner, bound to the top level
// depends on ipvp_pkg and incremental_pi_valve_positioner_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_pi_valve_positioner_assert.svh"
module ipvp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ipvp_pkg::rsp_type rsp_data
);

   logic req_take;
   logic rsp_wait;
   logic pos_at_limit;

   assign req_take     = req_valid && !req_stall;
   assign rsp_wait     = rsp_valid && rsp_stall;
   assign pos_at_limit = rsp_data.valve_position == 16'd0
                      || rsp_data.valve_position == ipvp_pkg::PosFull;

   `IPVP_ASSERT_NOW(a_reset_idle, clock, $past(reset) && !reset, !rsp_valid && !req_stall)
   `IPVP_ASSERT_NEXT(a_req_buffered, clock, reset, req_take, req_stall)
   `IPVP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))
   `IPVP_ASSERT_NOW(a_pos_range, clock, rsp_valid, rsp_data.valve_position <= ipvp_pkg::PosFull)
   `IPVP_ASSERT_NOW(a_clamp_at_limit, clock, rsp_valid && rsp_data.clamped, pos_at_limit)

endmodule

bind incremental_pi_valve_positioner ipvp_checker u_ipvp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
